// File: design/quaternion_orientation_integrator_defines.svh
// Assertion helpers for the integrator design file.
`ifndef QUATERNION_ORIENTATION_INTEGRATOR_DEFINES_SVH
`define QUATERNION_ORIENTATION_INTEGRATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define QOI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define QOI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/qoi_pkg.sv
package qoi_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam int CFG_WIDTH           = 32;
  localparam int CMD_WIDTH           = 2;
  localparam int RATE_WIDTH          = 32;
  localparam int STEP_WIDTH          = 32;
  localparam int QUAT_WIDTH          = 32;
  localparam int WIDE                = 64;
  localparam int VEC_FRAC            = 20;
  localparam int NUM_TERMS           = 12;
  localparam logic [CFG_WIDTH-1:0] START_W_RESET = 32'h4000_0000;

  typedef enum logic [1:0] {
    CMD_INTEGRATE = 2'd0,
    CMD_ROTATE    = 2'd1,
    CMD_RESTART   = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_W = 2'd0,
    REG_START_X = 2'd1,
    REG_START_Y = 2'd2,
    REG_START_Z = 2'd3
  } reg_idx_t;

  // Product scaling applied by the multiplier
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_HALF = 2'd1,
    SH_FRAC = 2'd2,
    SH_VEC  = 2'd3
  } shift_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HALF_GO,
    S_HALF_WAIT,
    S_TERM_GO,
    S_TERM_WAIT,
    S_SUM,
    S_SCALE,
    S_SQ_GO,
    S_SQ_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_COMMIT,
    S_OUT
  } state_t;

  // One Hamilton product term: coefficient (a,b,c), quaternion part, target, sign
  typedef struct packed {
    logic [1:0] coef;
    logic [1:0] qsel;
    logic [1:0] dest;
    logic       sub;
  } term_t;

  function automatic term_t term_of(input logic [3:0] t);
    term_t r;
    unique case (t)
      4'd0:    r = '{2'd0, 2'd1, 2'd0, 1'b1};
      4'd1:    r = '{2'd1, 2'd2, 2'd0, 1'b1};
      4'd2:    r = '{2'd2, 2'd3, 2'd0, 1'b1};
      4'd3:    r = '{2'd0, 2'd0, 2'd1, 1'b0};
      4'd4:    r = '{2'd1, 2'd3, 2'd1, 1'b0};
      4'd5:    r = '{2'd2, 2'd2, 2'd1, 1'b1};
      4'd6:    r = '{2'd0, 2'd3, 2'd2, 1'b1};
      4'd7:    r = '{2'd1, 2'd0, 2'd2, 1'b0};
      4'd8:    r = '{2'd2, 2'd1, 2'd2, 1'b0};
      4'd9:    r = '{2'd0, 2'd2, 2'd3, 1'b0};
      4'd10:   r = '{2'd1, 2'd1, 2'd3, 1'b1};
      4'd11:   r = '{2'd2, 2'd0, 2'd3, 1'b0};
      default: r = '{2'd0, 2'd0, 2'd0, 1'b0};
    endcase
    return r;
  endfunction

endpackage

// File: design/qoi_if.sv
interface qoi_req_if import qoi_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [CMD_WIDTH-1:0]         command;
  logic signed [RATE_WIDTH-1:0] rate_x;
  logic signed [RATE_WIDTH-1:0] rate_y;
  logic signed [RATE_WIDTH-1:0] rate_z;
  logic [STEP_WIDTH-1:0]        step_time;

  modport source (output valid, command, rate_x, rate_y, rate_z, step_time, input ready);
  modport sink   (input valid, command, rate_x, rate_y, rate_z, step_time, output ready);
endinterface

interface qoi_rsp_if import qoi_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  logic                         norm_fault;
  logic                         saturated;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, norm_fault, saturated,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, norm_fault, saturated,
                  output ready);
endinterface

// File: design/qoi_mul.sv
// Signed 64x64 multiply, four 32x32 partial products accumulated in turn,
// then a floor shift chosen by the scaling code, wrapped to 64 bits.
module qoi_mul import qoi_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  shift_t                 shift,
  input  logic signed [WIDE-1:0] a,
  input  logic signed [WIDE-1:0] b,
  output logic                   done,
  output logic signed [WIDE-1:0] result
);

  localparam int F    = COMPONENT_WIDTH - 2;
  localparam int HALF = 53 - F;

  logic [WIDE-1:0]   ua, ub;
  logic              neg;
  shift_t            sh;
  logic [2*WIDE-1:0] acc, acc_next;
  logic [1:0]        cnt;
  logic              busy, fin;
  logic [31:0]       pa, pb;
  logic [WIDE-1:0]   pp;
  logic [WIDE-1:0]   t;
  logic              rem;
  logic [WIDE-1:0]   res_c;

  always_comb begin
    pa = cnt[0] ? ua[63:32] : ua[31:0];
    pb = cnt[1] ? ub[63:32] : ub[31:0];
    pp = pa * pb;
    unique case ({1'b0, cnt[0]} + {1'b0, cnt[1]})
      2'd0:    acc_next = acc + {64'd0, pp};
      2'd1:    acc_next = acc + {32'd0, pp, 32'd0};
      default: acc_next = acc + {pp, 64'd0};
    endcase
  end

  always_comb begin
    unique case (sh)
      SH_NONE: begin t = acc[63:0];           rem = 1'b0;               end
      SH_HALF: begin t = acc[HALF+63:HALF];   rem = |acc[HALF-1:0];     end
      SH_FRAC: begin t = acc[F+63:F];         rem = |acc[F-1:0];        end
      default: begin t = acc[VEC_FRAC+63:VEC_FRAC]; rem = |acc[VEC_FRAC-1:0]; end
    endcase
    res_c = neg ? (64'd0 - (t + {63'd0, rem})) : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ua   <= a[WIDE-1] ? 64'd0 - a : a;
        ub   <= b[WIDE-1] ? 64'd0 - b : b;
        neg  <= a[WIDE-1] ^ b[WIDE-1];
        sh   <= shift;
        acc  <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin    <= 1'b0;
        done   <= 1'b1;
        result <= res_c;
      end
    end
  end

endmodule

// File: design/qoi_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
module qoi_sqrt import qoi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WIDE-1:0] x,
  output logic            done,
  output logic [31:0]     root
);

  logic [WIDE-1:0] rad, res, bit_v, trial;
  logic [4:0]      k;
  logic            busy;

  always_comb begin
    bit_v = 64'd1 << (6'd62 - {k, 1'b0});
    trial = res + bit_v;
  end

  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= x;
        res  <= '0;
        k    <= 5'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rad >= trial) begin
          rad <= rad - trial;
          res <= (res >> 1) + bit_v;
        end else begin
          res <= res >> 1;
        end
        k <= k + 5'd1;
        if (k == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/qoi_div.sv
// Restoring divider: num * 2^F / den with num < 2 * den, one bit per cycle.
module qoi_div import qoi_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  num,
  input  logic [31:0]                  den,
  output logic                         done,
  output logic [COMPONENT_WIDTH-2:0]   quot
);

  localparam int F  = COMPONENT_WIDTH - 2;
  localparam int QW = F + 1;
  localparam int CW = $clog2(F);

  logic [31:0]   rem;
  logic [32:0]   rem2;
  logic          ge;
  logic [CW-1:0] k;
  logic          busy;
  logic          q0;

  always_comb begin
    q0   = num >= den;
    rem2 = {rem, 1'b0};
    ge   = rem2 >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= q0 ? num - den : num;
        quot <= QW'(q0);
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 32'(rem2 - {1'b0, den}) : rem2[31:0];
        quot <= {quot[QW-2:0], ge};
        k    <= k + 1'b1;
        if (k == CW'(F - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/quaternion_orientation_integrator.sv
// Quaternion orientation integrator.
// Holds one orientation (w,x,y,z), signed Q2.F, F = COMPONENT_WIDTH - 2.
// Request channel (req): command plus rate_x/y/z and step_time. Integrate
// forms q + (0,rate*dt/2)*q and normalizes; rotate adds (0,v)*q and clips;
// restart reloads the orientation from the start registers. Every request
// returns one response (rsp) with the orientation in Q2.30 and the
// norm_fault / saturated flags. Start registers are written on wr_en with
// wr_index / wr_data; the user must write them only while idle, which the
// block does not enforce. One request at a time; req.ready is high only
// while idle. Restart or unused commands answer in the next cycle. Rotate
// runs 12 products through the one shared multiplier, then the sum;
// integrate runs 3 half-step and 12 term products, repeated one-bit
// magnitude scaling, 4 squares, the square root and the per-part divider.
// Reset loads the start registers with identity (w = 1.0) and the
// orientation from them. A stalled rsp.ready holds the response stable and
// keeps req.ready low until it is taken.
`include "quaternion_orientation_integrator_defines.svh"

module quaternion_orientation_integrator import qoi_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [CFG_WIDTH-1:0] wr_data,
  qoi_req_if.sink              req,
  qoi_rsp_if.source            rsp
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = W - 2;
  localparam int UP = (F >= 30) ? F - 30 : 0;
  localparam int DN = (F < 30) ? 30 - F : 0;
  localparam logic signed [WIDE-1:0] QMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [WIDE-1:0] QMIN = -QMAX - 64'sd1;

  function automatic logic signed [WIDE-1:0] sext(input logic signed [W-1:0] v);
    return {{(WIDE - W){v[W-1]}}, v};
  endfunction

  // Q2.30 register value to internal Q2.F
  function automatic logic signed [W-1:0] from_q(input logic [CFG_WIDTH-1:0] v);
    logic signed [WIDE-1:0] tmp;
    tmp = {{32{v[31]}}, v};
    tmp = (tmp <<< UP) >>> DN;
    return tmp[W-1:0];
  endfunction

  function automatic logic [QUAT_WIDTH-1:0] to_q(input logic signed [W-1:0] v);
    logic signed [WIDE-1:0] tmp;
    tmp = sext(v);
    tmp = (tmp >>> UP) <<< DN;
    return tmp[QUAT_WIDTH-1:0];
  endfunction

  // clip to Q2.F; top bit flags the clip
  function automatic logic [W:0] clip(input logic signed [WIDE-1:0] v);
    logic [W:0] r;
    if (v > QMAX)      r = {1'b1, QMAX[W-1:0]};
    else if (v < QMIN) r = {1'b1, QMIN[W-1:0]};
    else               r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  state_t state, state_next;

  logic [CFG_WIDTH-1:0]   start_q [4];
  logic signed [W-1:0]    q       [4];
  logic signed [W-1:0]    nq      [4];
  logic signed [WIDE-1:0] h       [3];
  logic signed [WIDE-1:0] d       [4];
  logic [WIDE-1:0]        mag     [4];
  logic signed [WIDE-1:0] rsum    [4];
  logic [W:0]             rclip   [4];
  logic [STEP_WIDTH-1:0]  dt;
  cmd_t                   cmd;
  logic [3:0]             idx;
  logic [WIDE-1:0]        sum;
  logic [31:0]            nroot;
  logic                   fault, sat;
  term_t                  tm;

  logic                   all_zero, any_hi, all_lo;
  logic                   mul_start, mul_done;
  shift_t                 mul_shift;
  logic signed [WIDE-1:0] mul_a, mul_b, mul_res, hsel;
  logic                   sqrt_start, sqrt_done;
  logic [31:0]            sqrt_root;
  logic                   div_start, div_done;
  logic [F:0]             div_quot;
  logic signed [WIDE-1:0] div_val;
  logic [W:0]             div_clip;
  logic                   in_mul_wait, restart_acc;

  qoi_mul #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_mul (
    .clk, .rst, .start(mul_start), .shift(mul_shift), .a(mul_a), .b(mul_b),
    .done(mul_done), .result(mul_res)
  );

  qoi_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .x(sum), .done(sqrt_done), .root(sqrt_root)
  );

  qoi_div #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_div (
    .clk, .rst, .start(div_start), .num(mag[idx[1:0]][31:0]), .den(nroot),
    .done(div_done), .quot(div_quot)
  );

  // Scaling tests on the four magnitudes
  always_comb begin
    all_zero = 1'b1;
    any_hi   = 1'b0;
    all_lo   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (mag[i] != '0) all_zero = 1'b0;
      if (mag[i][63:31] != '0) any_hi = 1'b1;
      if (mag[i][63:30] != '0) all_lo = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rsum[i]  = sext(q[i]) + d[i];
      rclip[i] = clip(rsum[i]);
    end
    tm = term_of(idx);
    unique case (tm.coef)
      2'd0:    hsel = h[0];
      2'd1:    hsel = h[1];
      default: hsel = h[2];
    endcase
    div_val  = d[idx[1:0]][63] ? 64'sd0 - WIDE'(div_quot) : WIDE'(div_quot);
    div_clip = clip(div_val);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (cmd_t'(req.command))
            CMD_INTEGRATE: state_next = S_HALF_GO;
            CMD_ROTATE:    state_next = S_TERM_GO;
            default:       state_next = S_OUT;
          endcase
        end
      end
      S_HALF_GO:   state_next = S_HALF_WAIT;
      S_HALF_WAIT: if (mul_done) state_next = (idx == 4'd2) ? S_TERM_GO : S_HALF_GO;
      S_TERM_GO:   state_next = S_TERM_WAIT;
      S_TERM_WAIT: if (mul_done) state_next = (idx == 4'(NUM_TERMS - 1)) ? S_SUM : S_TERM_GO;
      S_SUM:       state_next = (cmd == CMD_ROTATE) ? S_OUT : S_SCALE;
      S_SCALE: begin
        priority if (all_zero)        state_next = S_OUT;
        else if (any_hi || all_lo)    state_next = S_SCALE;
        else                          state_next = S_SQ_GO;
      end
      S_SQ_GO:     state_next = S_SQ_WAIT;
      S_SQ_WAIT:   if (mul_done) state_next = (idx == 4'd3) ? S_SQRT_GO : S_SQ_GO;
      S_SQRT_GO:   state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (sqrt_done) state_next = S_DIV_GO;
      S_DIV_GO:    state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_next = (idx == 4'd3) ? S_COMMIT : S_DIV_GO;
      S_COMMIT:    state_next = S_OUT;
      S_OUT:       if (rsp.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Unit controls and operand steering
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = hsel;
    mul_b      = sext(q[tm.qsel]);
    mul_shift  = (cmd == CMD_ROTATE) ? SH_VEC : SH_FRAC;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_HALF_GO: begin
        mul_start = 1'b1;
        mul_a     = h[idx[1:0] == 2'd0 ? 0 : (idx[1:0] == 2'd1 ? 1 : 2)];
        mul_b     = {32'd0, dt};
        mul_shift = SH_HALF;
      end
      S_TERM_GO: mul_start = 1'b1;
      S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = mag[idx[1:0]];
        mul_b     = mag[idx[1:0]];
        mul_shift = SH_NONE;
      end
      S_SQRT_GO: sqrt_start = 1'b1;
      S_DIV_GO:  div_start  = 1'b1;
      default: ;
    endcase
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = (state == S_OUT);
  assign rsp.quat_w     = to_q(q[0]);
  assign rsp.quat_x     = to_q(q[1]);
  assign rsp.quat_y     = to_q(q[2]);
  assign rsp.quat_z     = to_q(q[3]);
  assign rsp.norm_fault = fault;
  assign rsp.saturated  = sat;

  assign in_mul_wait = (state == S_HALF_WAIT) || (state == S_TERM_WAIT) ||
                       (state == S_SQ_WAIT);
  assign restart_acc = req.valid && req.ready && (req.command == CMD_RESTART);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_q[0] <= START_W_RESET;
      start_q[1] <= '0;
      start_q[2] <= '0;
      start_q[3] <= '0;
      q[0]       <= from_q(START_W_RESET);
      q[1]       <= '0;
      q[2]       <= '0;
      q[3]       <= '0;
      fault      <= 1'b0;
      sat        <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) start_q[wr_index] <= wr_data;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd   <= cmd_t'(req.command);
            h[0]  <= WIDE'(req.rate_x);
            h[1]  <= WIDE'(req.rate_y);
            h[2]  <= WIDE'(req.rate_z);
            dt    <= req.step_time;
            idx   <= 4'd0;
            fault <= 1'b0;
            sat   <= 1'b0;
            for (int i = 0; i < 4; i++) d[i] <= '0;
            if (cmd_t'(req.command) == CMD_RESTART) begin
              for (int i = 0; i < 4; i++) q[i] <= from_q(start_q[i]);
            end
          end
        end
        S_HALF_WAIT: begin
          if (mul_done) begin
            h[idx[1:0] == 2'd0 ? 0 : (idx[1:0] == 2'd1 ? 1 : 2)] <= mul_res;
            idx <= (idx == 4'd2) ? 4'd0 : idx + 4'd1;
          end
        end
        S_TERM_WAIT: begin
          if (mul_done) begin
            d[tm.dest] <= tm.sub ? d[tm.dest] - mul_res : d[tm.dest] + mul_res;
            idx <= (idx == 4'(NUM_TERMS - 1)) ? 4'd0 : idx + 4'd1;
          end
        end
        S_SUM: begin
          for (int i = 0; i < 4; i++) begin
            if (cmd == CMD_ROTATE) begin
              q[i] <= rclip[i][W-1:0];
            end else begin
              d[i]   <= rsum[i];
              mag[i] <= rsum[i][63] ? 64'd0 - rsum[i] : rsum[i];
            end
          end
          if (cmd == CMD_ROTATE)
            sat <= rclip[0][W] | rclip[1][W] | rclip[2][W] | rclip[3][W];
        end
        S_SCALE: begin
          sum <= '0;
          priority if (all_zero) begin
            fault <= 1'b1;
          end else if (any_hi) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
          end else if (all_lo) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] << 1;
          end
        end
        S_SQ_WAIT: begin
          if (mul_done) begin
            sum <= sum + mul_res;
            idx <= (idx == 4'd3) ? 4'd0 : idx + 4'd1;
          end
        end
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            nroot <= sqrt_root;
            idx   <= 4'd0;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            nq[idx[1:0]] <= div_clip[W-1:0];
            if (div_clip[W]) sat <= 1'b1;
            idx <= (idx == 4'd3) ? 4'd0 : idx + 4'd1;
          end
        end
        S_COMMIT: begin
          for (int i = 0; i < 4; i++) q[i] <= nq[i];
        end
        default: ;
      endcase
    end
  end

  `QOI_ASSERT(a_no_overlap, !(req.ready && rsp.valid), "request taken while response pending")
  `QOI_ASSERT(a_mul_done_wait, mul_done |-> in_mul_wait, "multiplier result outside a wait state")
  `QOI_ASSERT(a_flags_excl, rsp.valid |-> !(rsp.norm_fault && rsp.saturated), "fault and clip")
  `QOI_ASSERT(a_restart_fast, restart_acc |=> (state == S_OUT), "restart not answered next cycle")
  `QOI_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE), "not idle after reset")

endmodule
